### hdl/fat12te_pkg.sv
// Shared types and constants of the FAT12 table engine.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package fat12te_pkg;

  // Command codes of the input beat
  typedef enum logic [2:0] {
    CMD_READ_ENTRY  = 3'd0,
    CMD_WRITE_ENTRY = 3'd1,
    CMD_FIND_FREE   = 3'd2,
    CMD_ALLOC_LINK  = 3'd3,
    CMD_LOAD_BYTE   = 3'd4,
    CMD_READ_BYTE   = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_CHK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_BWAIT,
    S_FINISH
  } state_t;

  // What the entry read sequence is doing
  typedef enum logic [2:0] {
    PH_READ,
    PH_WRITE,
    PH_SCAN,
    PH_LINK,
    PH_MARK
  } phase_t;

  localparam logic [11:0] ENTRY_FREE = 12'h000;
  localparam logic [11:0] ENTRY_EOC  = 12'hFF8;
  localparam logic [11:0] ENTRY_END  = 12'hFFF;
  localparam logic [12:0] FIRST_DATA_CLUSTER = 13'd2;
  localparam logic [12:0] LIMIT_RESET = 13'd2848;

endpackage

### hdl/fat12te_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fat12te_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fat12_table_engine_core.sv
// FAT12 allocation table engine: byte image in RAM, sequencer over one address unit.
// Depends on fat12te_pkg and fat12te_ram.
// Free search: clusters are examined one at a time, with the two byte reads per entry
//   on the single RAM read port; allocate adds a read-modify-write per entry update (link, end mark).
// One command at a time; in_ready is low while a command runs.
// Reset: synchronous; then a clearing pass zeroes every byte of the image
//   before the first command is taken. cluster_limit resets to 2848.
`timescale 1ns / 1ps

module fat12_table_engine_core
  import fat12te_pkg::*;
#(
  parameter int TABLE_BYTES  = 6144,
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel (cluster_limit)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [11:0] cluster,
  input  logic [11:0] entry_in,
  input  logic        link_previous,
  input  logic [12:0] byte_index,
  input  logic [7:0]  byte_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] entry_out,
  output logic        end_of_chain,
  output logic [11:0] found_cluster,
  output logic [7:0]  byte_out,
  output logic [1:0]  status
);

  localparam int AW = $clog2(TABLE_BYTES);
  localparam logic [13:0] TB = 14'(TABLE_BYTES);
  localparam logic [12:0] MC = 13'(MAX_CLUSTERS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BYTES - 1);

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  state_t      state, state_next;
  phase_t      phase, phase_next;
  cmd_t        cmd, cmd_next;
  logic [12:0] limit, limit_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [12:0] cur, cur_next;        // cluster under work / scan pointer
  logic [11:0] prev, prev_next;      // cluster to link
  logic [11:0] found, found_next;    // cluster found by the scan
  logic [11:0] val, val_next;        // entry value to store
  logic        link, link_next;
  logic [12:0] bidx, bidx_next;
  logic [7:0]  bval, bval_next;
  logic [7:0]  lo, lo_next;          // low byte of the entry word
  logic [15:0] wword, wword_next;    // merged word to write back
  logic [11:0] res_eo, res_eo_next;
  logic        res_eoc, res_eoc_next;
  logic [11:0] res_fc, res_fc_next;
  logic [7:0]  res_bo, res_bo_next;
  status_t     res_st, res_st_next;
  logic        out_valid_next;
  logic [11:0] entry_out_next, found_cluster_next;
  logic        end_of_chain_next;
  logic [7:0]  byte_out_next;
  logic [1:0]  status_next;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // ---------------------------------------------------------------
  // Shared address unit: byte position of cur and its range check
  // ---------------------------------------------------------------
  logic [13:0] pos, pos1;
  logic        fits;
  logic        bidx_ok;
  logic [15:0] word;
  logic [11:0] entry_val;
  logic [15:0] merged;

  assign pos  = {1'b0, cur} + {2'b00, cur[12:1]};
  assign pos1 = pos + 14'd1;
  assign fits = (cur < MC) && (pos1 < TB);
  assign bidx_ok = {1'b0, bidx} < TB;

  // little-endian pair; odd clusters sit in the high 12 bits
  assign word      = {ram_rdata, lo};
  assign entry_val = cur[0] ? word[15:4] : word[11:0];
  assign merged    = cur[0] ? {val, word[3:0]} : {word[15:12], val};

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  fat12te_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // State register and datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      limit     <= LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      limit     <= limit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    phase         <= phase_next;
    cmd           <= cmd_next;
    cur           <= cur_next;
    prev          <= prev_next;
    found         <= found_next;
    val           <= val_next;
    link          <= link_next;
    bidx          <= bidx_next;
    bval          <= bval_next;
    lo            <= lo_next;
    wword         <= wword_next;
    res_eo        <= res_eo_next;
    res_eoc       <= res_eoc_next;
    res_fc        <= res_fc_next;
    res_bo        <= res_bo_next;
    res_st        <= res_st_next;
    entry_out     <= entry_out_next;
    end_of_chain  <= end_of_chain_next;
    found_cluster <= found_cluster_next;
    byte_out      <= byte_out_next;
    status        <= status_next;
  end

  // ---------------------------------------------------------------
  // Sequencer: next state, datapath updates, RAM controls
  // ---------------------------------------------------------------
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    cmd_next      = cmd;
    limit_next    = limit;
    clr_addr_next = clr_addr;
    cur_next      = cur;
    prev_next     = prev;
    found_next    = found;
    val_next      = val;
    link_next     = link;
    bidx_next     = bidx;
    bval_next     = bval;
    lo_next       = lo;
    wword_next    = wword;
    res_eo_next   = res_eo;
    res_eoc_next  = res_eoc;
    res_fc_next   = res_fc;
    res_bo_next   = res_bo;
    res_st_next   = res_st;
    entry_out_next     = entry_out;
    end_of_chain_next  = end_of_chain;
    found_cluster_next = found_cluster;
    byte_out_next      = byte_out;
    status_next        = status;
    out_valid_next     = out_valid && !out_ready;

    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = 8'h00;
    ram_raddr = pos[AW-1:0];

    if (cfg_valid) begin
      limit_next = cfg_data;
    end

    unique case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_next     = cmd_t'(command);
          cur_next     = {1'b0, cluster};
          val_next     = entry_in;
          link_next    = link_previous;
          bidx_next    = byte_index;
          bval_next    = byte_in;
          res_eo_next  = '0;
          res_eoc_next = 1'b0;
          res_fc_next  = '0;
          res_bo_next  = '0;
          res_st_next  = STAT_OK;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_FINISH;
        unique case (cmd)
          CMD_READ_ENTRY, CMD_WRITE_ENTRY: begin
            phase_next = (cmd == CMD_READ_ENTRY) ? PH_READ : PH_WRITE;
            if (fits) begin
              state_next = S_RD0;
            end else begin
              res_st_next = STAT_RANGE;
            end
          end
          CMD_FIND_FREE: begin
            cur_next   = FIRST_DATA_CLUSTER;
            state_next = S_SCAN_CHK;
          end
          CMD_ALLOC_LINK: begin
            if (link && !fits) begin
              res_st_next = STAT_RANGE;
            end else begin
              prev_next  = cur[11:0];
              cur_next   = FIRST_DATA_CLUSTER;
              state_next = S_SCAN_CHK;
            end
          end
          CMD_LOAD_BYTE: begin
            if (bidx_ok) begin
              ram_we    = 1'b1;
              ram_waddr = bidx[AW-1:0];
              ram_wdata = bval;
            end else begin
              res_st_next = STAT_RANGE;
            end
          end
          CMD_READ_BYTE: begin
            if (bidx_ok) begin
              ram_raddr  = bidx[AW-1:0];
              state_next = S_BWAIT;
            end else begin
              res_st_next = STAT_RANGE;
            end
          end
          default: begin
            res_st_next = STAT_RANGE;
          end
        endcase
      end

      S_SCAN_CHK: begin
        if ((cur < limit) && fits) begin
          phase_next = PH_SCAN;
          state_next = S_RD0;
        end else begin
          res_st_next = STAT_NOFREE;
          res_fc_next = '0;
          state_next  = S_FINISH;
        end
      end

      // two byte reads of the entry word; data comes in the cycle after its address
      S_RD0: begin
        ram_raddr  = pos[AW-1:0];
        state_next = S_RD1;
      end

      S_RD1: begin
        ram_raddr  = pos1[AW-1:0];
        lo_next    = ram_rdata;
        state_next = S_RD2;
      end

      S_RD2: begin
        wword_next = merged;
        unique case (phase)
          PH_READ: begin
            res_eo_next  = entry_val;
            res_eoc_next = (entry_val >= ENTRY_EOC);
            state_next   = S_FINISH;
          end
          PH_SCAN: begin
            if (entry_val == ENTRY_FREE) begin
              found_next  = cur[11:0];
              res_fc_next = cur[11:0];
              if (cmd == CMD_ALLOC_LINK) begin
                state_next = S_RD0;
                if (link) begin
                  // link first, so a self link ends as the end mark
                  phase_next = PH_LINK;
                  cur_next   = {1'b0, prev};
                  val_next   = cur[11:0];
                end else begin
                  phase_next = PH_MARK;
                  val_next   = ENTRY_END;
                end
              end else begin
                state_next = S_FINISH;
              end
            end else begin
              cur_next   = cur + 13'd1;
              state_next = S_SCAN_CHK;
            end
          end
          default: begin
            state_next = S_WR0;
          end
        endcase
      end

      S_WR0: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = wword[7:0];
        state_next = S_WR1;
      end

      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = pos1[AW-1:0];
        ram_wdata = wword[15:8];
        if (phase == PH_LINK) begin
          phase_next = PH_MARK;
          cur_next   = {1'b0, found};
          val_next   = ENTRY_END;
          state_next = S_RD0;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_BWAIT: begin
        res_bo_next = ram_rdata;
        state_next  = S_FINISH;
      end

      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          entry_out_next     = res_eo;
          end_of_chain_next  = res_eoc;
          found_cluster_next = res_fc;
          byte_out_next      = res_bo;
          status_next        = res_st;
          out_valid_next     = 1'b1;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted beat did not enter decode");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NOFREE |-> found_cluster == 12'd0)
    else $error("no-free result carries a cluster");

  a_eoc_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_chain |-> entry_out >= ENTRY_EOC)
    else $error("end of chain flagged below 0xFF8");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> {1'b0, ram_waddr} < 14'(TABLE_BYTES))
    else $error("RAM write beyond image");

  a_ready_not_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready && !out_valid)
    else $error("beat activity during clearing pass");

endmodule
